// ----- hw/rtl/fqs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the FIFO queue with content search.
// Used by fqs_ctrl, fqs_dp and fifo_queue_with_search; depends on nothing.
package fqs_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int OUT_W  = 112;

    typedef enum logic [1:0] {
        OP_ENQ    = 2'd0,
        OP_DEQ    = 2'd1,
        OP_SEARCH = 2'd2,
        OP_STATUS = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FRONT_RD,
        ST_FRONT_LD,
        ST_SEARCH_RD,
        ST_SEARCH_CMP,
        ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic exec;
        logic front_rd;
        logic front_ld;
        logic srch_rd;
        logic srch_cmp;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        op_t  op;
        logic more_than_one;
        logic search_end;
        logic match;
    } sts_t;

endpackage

// ----- hw/rtl/fqs_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine of the FIFO queue with content search.
// Depends on fqs_pkg; drives the commands of fqs_dp and the stream handshakes.
module fqs_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  fqs_pkg::sts_t sts,
    output fqs_pkg::cmd_t cmd
);

    fqs_pkg::state_t state_reg;
    fqs_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fqs_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = fqs_pkg::ST_EXEC;
                end
            end
            fqs_pkg::ST_EXEC:
            begin
                if (sts.op == fqs_pkg::OP_DEQ && sts.more_than_one)
                begin
                    state_next = fqs_pkg::ST_FRONT_RD;
                end
                else if (sts.op == fqs_pkg::OP_SEARCH)
                begin
                    state_next = fqs_pkg::ST_SEARCH_RD;
                end
                else
                begin
                    state_next = fqs_pkg::ST_DONE;
                end
            end
            fqs_pkg::ST_FRONT_RD:
            begin
                state_next = fqs_pkg::ST_FRONT_LD;
            end
            fqs_pkg::ST_FRONT_LD:
            begin
                state_next = fqs_pkg::ST_DONE;
            end
            fqs_pkg::ST_SEARCH_RD:
            begin
                if (sts.search_end)
                begin
                    state_next = fqs_pkg::ST_DONE;
                end
                else
                begin
                    state_next = fqs_pkg::ST_SEARCH_CMP;
                end
            end
            fqs_pkg::ST_SEARCH_CMP:
            begin
                if (sts.match)
                begin
                    state_next = fqs_pkg::ST_DONE;
                end
                else
                begin
                    state_next = fqs_pkg::ST_SEARCH_RD;
                end
            end
            fqs_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = fqs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fqs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            fqs_pkg::ST_IDLE:
            begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            fqs_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            fqs_pkg::ST_FRONT_RD:
            begin
                cmd.front_rd = 1'b1;
            end
            fqs_pkg::ST_FRONT_LD:
            begin
                cmd.front_ld = 1'b1;
            end
            fqs_pkg::ST_SEARCH_RD:
            begin
                cmd.srch_rd = !sts.search_end;
            end
            fqs_pkg::ST_SEARCH_CMP:
            begin
                cmd.srch_cmp = 1'b1;
            end
            fqs_pkg::ST_DONE:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fqs_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- hw/rtl/fqs_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the FIFO queue with content search: ring memory, pointers,
// search counter and result register. Depends on fqs_pkg.
module fqs_dp
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [1:0]                  in_op,
    input  logic [fqs_pkg::DATA_W-1:0]  in_value,
    input  fqs_pkg::cmd_t               cmd,
    output fqs_pkg::sts_t               sts,
    output logic [fqs_pkg::OUT_W-1:0]   out_data
);

    logic [fqs_pkg::DATA_W-1:0] mem [fqs_pkg::DEPTH];
    logic [fqs_pkg::DATA_W-1:0] rd_data_reg;
    logic [fqs_pkg::ADDR_W-1:0] rd_addr;

    fqs_pkg::op_t               op_reg;
    logic [fqs_pkg::DATA_W-1:0] key_reg;
    logic [fqs_pkg::ADDR_W-1:0] head_reg;
    logic [fqs_pkg::ADDR_W-1:0] head_next;
    logic [fqs_pkg::ADDR_W-1:0] tail_reg;
    logic [fqs_pkg::ADDR_W-1:0] tail_next;
    logic [fqs_pkg::CNT_W-1:0]  count_reg;
    logic [fqs_pkg::CNT_W-1:0]  count_next;
    logic [fqs_pkg::DATA_W-1:0] front_reg;
    logic [fqs_pkg::DATA_W-1:0] front_next;
    logic [fqs_pkg::DATA_W-1:0] back_reg;
    logic [fqs_pkg::DATA_W-1:0] back_next;
    logic [fqs_pkg::CNT_W-1:0]  idx_reg;
    logic [fqs_pkg::CNT_W-1:0]  idx_next;
    logic [fqs_pkg::DATA_W-1:0] deq_reg;
    logic [fqs_pkg::DATA_W-1:0] deq_next;
    logic                       found_reg;
    logic                       found_next;
    logic [fqs_pkg::CNT_W-1:0]  pos_reg;
    logic [fqs_pkg::CNT_W-1:0]  pos_next;
    logic                       drop_reg;
    logic                       drop_next;
    logic [fqs_pkg::OUT_W-1:0]  out_reg;
    logic [fqs_pkg::OUT_W-1:0]  out_next;

    logic                       is_full;
    logic                       is_empty;
    logic                       do_write;

    assign is_full  = count_reg == fqs_pkg::CNT_W'(fqs_pkg::DEPTH);
    assign is_empty = count_reg == '0;
    assign do_write = cmd.exec && op_reg == fqs_pkg::OP_ENQ && !is_full;

    // The ring is walked from the head; the address wraps naturally.
    assign rd_addr = cmd.front_rd ? head_reg
                                  : head_reg + idx_reg[fqs_pkg::ADDR_W-1:0];

    // The read register only loads when the controller asks for a word.
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[tail_reg] <= key_reg;
        end
        if (cmd.front_rd || cmd.srch_rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign sts.op            = op_reg;
    assign sts.more_than_one = count_reg > fqs_pkg::CNT_W'(1);
    assign sts.search_end    = idx_reg == count_reg;
    assign sts.match         = rd_data_reg == key_reg;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        front_next = front_reg;
        back_next  = back_reg;
        idx_next   = idx_reg;
        deq_next   = deq_reg;
        found_next = found_reg;
        pos_next   = pos_reg;
        drop_next  = drop_reg;
        out_next   = out_reg;

        if (cmd.accept)
        begin
            deq_next   = '0;
            found_next = 1'b0;
            pos_next   = '0;
            drop_next  = 1'b0;
            idx_next   = '0;
        end

        if (cmd.exec)
        begin
            case (op_reg)
                fqs_pkg::OP_ENQ:
                begin
                    if (is_full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        tail_next  = tail_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                        back_next  = key_reg;
                        if (is_empty)
                        begin
                            front_next = key_reg;
                        end
                    end
                end
                fqs_pkg::OP_DEQ:
                begin
                    if (!is_empty)
                    begin
                        deq_next   = front_reg;
                        head_next  = head_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    idx_next = '0;
                end
            endcase
        end

        if (cmd.front_ld)
        begin
            front_next = rd_data_reg;
        end

        if (cmd.srch_cmp)
        begin
            if (sts.match)
            begin
                found_next = 1'b1;
                pos_next   = idx_reg + 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end

        if (cmd.load_out)
        begin
            out_next = {3'b000,
                        drop_reg,
                        pos_reg,
                        found_reg,
                        is_empty,
                        count_reg,
                        is_empty ? {fqs_pkg::DATA_W{1'b0}} : back_reg,
                        is_empty ? {fqs_pkg::DATA_W{1'b0}} : front_reg,
                        deq_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= fqs_pkg::op_t'(in_op);
            key_reg <= in_value;
        end
        front_reg <= front_next;
        back_reg  <= back_next;
        idx_reg   <= idx_next;
        deq_reg   <= deq_next;
        found_reg <= found_next;
        pos_reg   <= pos_next;
        drop_reg  <= drop_next;
        out_reg   <= out_next;
    end

    assign out_data = out_reg;

endmodule

// ----- hw/rtl/fifo_queue_with_search.sv -----
`timescale 1ns / 1ps
// Top level of the FIFO queue with content search.
// Depends on fqs_pkg, fqs_ctrl and fqs_dp.
//
// A 16-entry ring of signed 32-bit words that takes one request at a time:
// enqueue, dequeue, search for a key, or status only. Every request gives
// exactly one result carrying the dequeued word (0 unless a dequeue
// succeeded), the front and back words (0 when empty), the count, the empty
// flag, the search outcome (found and 1-based position from the front) and
// a dropped flag for an enqueue into a full ring. The words live in a
// single-port memory with a registered read. An enqueue, a status request,
// or a dequeue that finds the ring empty or leaves it empty needs no read
// from the memory; a dequeue that leaves one or more words reads the new
// front word back from the memory, and a search reads and compares the held
// words one at a time from the front until it finds a match or has compared
// every held word. The result sits in an output register, so the next request
// is accepted while the previous result is still waiting to be taken; only
// when a finished result finds that register still full does the block wait
// for the downstream side.
module fifo_queue_with_search
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [31:0]                s_tdata,   // [31:0] value
    input  logic [1:0]                 s_tuser,   // [1:0] op
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [31:0] dequeued_value, [63:32] front_value, [95:64] back_value,
    // [100:96] count, [101] is_empty, [102] found, [107:103] position,
    // [108] dropped, [111:109] zero
    output logic [fqs_pkg::OUT_W-1:0]  m_tdata
);

    fqs_pkg::cmd_t cmd;
    fqs_pkg::sts_t sts;

    // The controller sequences each request and owns both handshakes.
    fqs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The datapath holds the ring, its pointers and the result register.
    fqs_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_op    (s_tuser),
        .in_value (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (m_tdata)
    );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of fifo_queue_with_search: a directed table, then biased random
// enqueue, dequeue, search and status requests, with random idling on both stream sides.
// Depends on fqs_pkg and the fifo_queue_with_search RTL.
module tb;

    import fqs_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 725;
    localparam int STEADY_ITEMS = 100;
    localparam int DRAIN_CYCLES = 40;

    // One result, laid out as m_tdata[108:0] from the top bit down.
    typedef struct packed {
        logic              dropped;
        logic [CNT_W-1:0]  position;
        logic              found;
        logic              is_empty;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] back;
        logic [DATA_W-1:0] front;
        logic [DATA_W-1:0] dequeued;
    } queue_status_t;

    typedef struct {
        op_t           op;
        logic [31:0]   value;
        logic          typed;
        queue_status_t result;
    } stim_row_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    // Our own copy of the ring, updated at every accepted request.
    logic [DATA_W-1:0] ring_words [DEPTH];
    logic [ADDR_W-1:0] ring_head = '0;
    logic [ADDR_W-1:0] ring_tail = '0;
    logic [CNT_W-1:0]  ring_count = '0;

    queue_status_t pending_status [$];
    stim_row_t     directed_rows [$];
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count = 0;
    int unsigned   stall_left = 0;
    logic          sender_idle = 1'b1;
    logic          receiver_idle = 1'b1;

    fifo_queue_with_search i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %h, expected %h", name, got, want));
    endtask

    // Applies one request to the ring copy and returns the status it produces.
    function automatic queue_status_t next_queue_status(input op_t op,
                                                        input logic [31:0] word);
        queue_status_t r;
        logic [ADDR_W-1:0] slot;
        r = '0;
        slot = ring_head;
        case (op)
            OP_ENQ:
            begin
                if (ring_count == CNT_W'(DEPTH))
                    r.dropped = 1'b1;
                else
                begin
                    ring_words[ring_tail] = word;
                    ring_tail = ring_tail + 1'b1;
                    ring_count = ring_count + 1'b1;
                end
            end
            OP_DEQ:
            begin
                if (ring_count != 0)
                begin
                    r.dequeued = ring_words[ring_head];
                    ring_head = ring_head + 1'b1;
                    ring_count = ring_count - 1'b1;
                end
            end
            OP_SEARCH:
            begin
                // The first match from the front wins.
                for (int k = 0; k < ring_count; k++)
                begin
                    if (!r.found && ring_words[slot] == word)
                    begin
                        r.found = 1'b1;
                        r.position = CNT_W'(k + 1);
                    end
                    slot = slot + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (ring_count != 0)
        begin
            r.front = ring_words[ring_head];
            r.back  = ring_words[ring_tail - 1'b1];
        end
        r.count    = ring_count;
        r.is_empty = (ring_count == 0);
        return r;
    endfunction

    // Drives one request, waits for it to be taken, and records what it should give.
    task automatic send_request(input op_t op, input logic [31:0] value, input logic typed,
                                input queue_status_t typed_result);
        queue_status_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predicted = next_queue_status(op, value);
        pending_status.push_back(typed ? typed_result : predicted);
        if (sender_idle && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
    endtask

    function automatic void add_row(input op_t op, input logic [31:0] value);
        stim_row_t row;
        row.op = op;
        row.value = value;
        row.typed = 1'b0;
        row.result = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_typed_row(input op_t op, input logic [31:0] value,
        input logic [31:0] dequeued, input logic [31:0] front, input logic [31:0] back,
        input int count, input logic found, input int position, input logic dropped);
        stim_row_t row;
        row.op = op;
        row.value = value;
        row.typed = 1'b1;
        row.result.dequeued = dequeued;
        row.result.front    = front;
        row.result.back     = back;
        row.result.count    = CNT_W'(count);
        row.result.is_empty = (count == 0);
        row.result.found    = found;
        row.result.position = CNT_W'(position);
        row.result.dropped  = dropped;
        directed_rows.push_back(row);
    endfunction

    // Results are checked as they are taken; the ready side stalls in short bursts.
    always @(posedge clk)
    begin : take_results
        queue_status_t got;
        queue_status_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = queue_status_t'(m_tdata[108:0]);
            if (pending_status.size() == 0)
                report_mismatch($sformatf("result %h with no request waiting", m_tdata));
            else
            begin
                want = pending_status.pop_front();
                check_field("dequeued_value", got.dequeued, want.dequeued);
                check_field("front_value", got.front, want.front);
                check_field("back_value", got.back, want.back);
                check_field("count", 32'(got.count), 32'(want.count));
                check_field("is_empty", 32'(got.is_empty), 32'(want.is_empty));
                check_field("found", 32'(got.found), 32'(want.found));
                check_field("position", 32'(got.position), 32'(want.position));
                check_field("dropped", 32'(got.dropped), 32'(want.dropped));
            end
        end
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (receiver_idle && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 6);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int unsigned   mode;
        int unsigned   phase_left;
        int unsigned   roll;
        int unsigned   enq_share;
        int unsigned   deq_share;
        op_t           op;
        logic [31:0]   value;
        logic [ADDR_W-1:0] pick;

        // Empty queue, then the word extremes, then a fill with repeated words up to the
        // full ring, a refused enqueue, searches across the full range and a dequeue.
        add_typed_row(OP_STATUS, 32'h0000_0000, '0, '0, '0, 0, 1'b0, 0, 1'b0);
        add_typed_row(OP_DEQ,    32'hFFFF_FFFF, '0, '0, '0, 0, 1'b0, 0, 1'b0);
        add_typed_row(OP_SEARCH, 32'h0000_0000, '0, '0, '0, 0, 1'b0, 0, 1'b0);
        add_typed_row(OP_ENQ, 32'h8000_0000, '0, 32'h8000_0000, 32'h8000_0000,
                      1, 1'b0, 0, 1'b0);
        add_typed_row(OP_ENQ, 32'h7FFF_FFFF, '0, 32'h8000_0000, 32'h7FFF_FFFF,
                      2, 1'b0, 0, 1'b0);
        add_typed_row(OP_SEARCH, 32'h7FFF_FFFF, '0, 32'h8000_0000, 32'h7FFF_FFFF,
                      2, 1'b1, 2, 1'b0);
        add_row(OP_ENQ, 32'hFFFF_FFFF);
        add_row(OP_ENQ, 32'h0000_0000);
        add_row(OP_ENQ, 32'h0000_0001);
        add_row(OP_ENQ, 32'h5555_5555);
        add_row(OP_ENQ, 32'hAAAA_AAAA);
        add_row(OP_ENQ, 32'hFFFF_FFFF);
        add_row(OP_ENQ, 32'h0000_00FF);
        add_row(OP_ENQ, 32'h8000_0001);
        add_row(OP_ENQ, 32'h7FFF_FFFE);
        add_row(OP_ENQ, 32'h0F0F_0F0F);
        add_row(OP_ENQ, 32'hF0F0_F0F0);
        add_row(OP_ENQ, 32'hFFFF_FFFE);
        add_row(OP_ENQ, 32'h0000_8000);
        add_row(OP_ENQ, 32'h1234_5678);
        add_typed_row(OP_ENQ, 32'hDEAD_BEEF, '0, 32'h8000_0000, 32'h1234_5678,
                      16, 1'b0, 0, 1'b1);
        add_row(OP_SEARCH, 32'hFFFF_FFFF);
        add_row(OP_SEARCH, 32'h1234_5678);
        add_row(OP_SEARCH, 32'hDEAD_BEEF);
        add_typed_row(OP_DEQ, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678,
                      15, 1'b0, 0, 1'b0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].value, directed_rows[i].typed,
                         directed_rows[i].result);

        // Random part in phases that lean toward filling, draining or neither, so the
        // ring keeps passing through both full and empty.
        mode = 0;
        phase_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                mode = $urandom_range(0, 2);
                phase_left = $urandom_range(20, 60);
                sender_idle = ($urandom_range(0, 3) != 0);
                receiver_idle = ($urandom_range(0, 3) != 0);
            end
            phase_left--;
            if (n >= RANDOM_ITEMS - STEADY_ITEMS)
            begin
                sender_idle = 1'b0;
                receiver_idle = 1'b0;
            end

            enq_share = (mode == 0) ? 55 : (mode == 1) ? 15 : 35;
            deq_share = (mode == 1) ? 55 : (mode == 0) ? 15 : 35;
            roll = $urandom_range(0, 99);
            if (roll < enq_share)
                op = OP_ENQ;
            else if (roll < enq_share + deq_share)
                op = OP_DEQ;
            else if (roll < 92)
                op = OP_SEARCH;
            else
                op = OP_STATUS;

            // Small words repeat often, so searches see duplicates; extremes turn up too.
            roll = $urandom_range(0, 9);
            if (roll < 3)
                value = $urandom_range(0, 7) - 4;
            else if (roll == 3)
                value = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            else
                value = $urandom;
            if (op == OP_SEARCH && ring_count != 0 && $urandom_range(0, 2) != 0)
            begin
                pick = ring_head + ADDR_W'($urandom_range(0, ring_count - 1));
                value = ring_words[pick];
            end

            send_request(op, value, 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- fifo_queue_with_search.f -----
hw/rtl/fqs_pkg.sv
hw/rtl/fqs_ctrl.sv
hw/rtl/fqs_dp.sv
hw/rtl/fifo_queue_with_search.sv
tb/tb.sv
